// ===== design/keyed_activity_rate_limiter_macros.svh =====
// Assertion helpers for the rate limiter design file.
`ifndef KEYED_ACTIVITY_RATE_LIMITER_MACROS_SVH
`define KEYED_ACTIVITY_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define KAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define KAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kar_pkg.sv =====
`default_nettype none
package kar_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int KEY_BITS_DEF = 64;

    localparam logic [15:0] RATE_LIMIT_RESET = 16'd3;
    localparam logic [15:0] DEBOUNCE_RESET   = 16'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_RATE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;

    localparam logic [8:0] STOPPED_MAX = 9'd511;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_SWEEP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_APPLY
    } t_state;

    // request to the shared age compare unit
    typedef struct packed {
        logic [31:0] now;
        logic [31:0] stamp;
        logic [15:0] limit;
    } t_age_req;

endpackage
`default_nettype wire

// ===== design/keyed_activity_rate_limiter.sv =====
`default_nettype none
// Keyed activity rate limiter.
// Input channel (i_in_valid / o_in_ready) carries one word: action, user key
// and current time. Output channel (o_out_valid / i_out_ready) returns one
// result word per input word: broadcast, typing, stopped count, no room.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes register 0
// (rate limit) or 1 (debounce); other indexes are dropped. Write it only idle.
// Start, stop and query scan the entry table one entry per cycle through the
// single read port of the entry memory and end at a matching key or at the
// last stored entry; on an empty table a word goes straight to its final step.
// A sweep scans every stored entry the same way.
// o_in_ready is high only in the idle state, from the cycle the previous
// result appears; the next word is taken while that result still waits.
// When the receiver stalls, a finished result holds in the output register
// and a following word waits in its final step until the register frees.
// Reset clears the entry count, the state and the registers (to 3 and 5);
// the entry memory needs no clearing pass, entries are written on append.
module keyed_activity_rate_limiter #(
    parameter int ENTRIES  = kar_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = kar_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_user_key,
    input  logic [31:0] i_now_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_broadcast,
    output logic        o_typing,
    output logic [8:0]  o_stopped_count,
    output logic        o_no_room,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "keyed_activity_rate_limiter_macros.svh"

    localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW       = $clog2(ENTRIES + 1);
    localparam int OFS_LAST = 32;
    localparam int OFS_ACT  = 64;
    localparam int OFS_KEY  = 65;
    localparam int W        = KEY_BITS + OFS_KEY;

    kar_pkg::t_state  r_state, n_state;
    kar_pkg::t_action r_action;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_now;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_found, n_found;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_count, n_count;
    logic [15:0]         r_rate, r_deb;
    logic                r_out_valid;
    logic                r_bc, r_typ, r_full;
    logic [8:0]          r_cnt;
    logic [W-1:0]        r_rd_data;

    logic [W-1:0] m_entry [ENTRIES];

    logic          in_fire, out_free;
    logic          mem_rd_en, mem_we;
    logic [AW-1:0] mem_rd_addr, mem_wr_addr;
    logic [W-1:0]  mem_wr_data;

    logic [KEY_BITS-1:0] rd_key;
    logic                rd_act;
    logic [31:0]         rd_last, rd_first;
    logic                key_match, idx_last, room, hit_or_room;
    logic                base_act, start_ok, age_ge;
    logic [31:0]         base_last, base_first;
    logic                new_act;
    logic [31:0]         new_last, new_first;
    logic                res_bc, res_typ, res_full;
    logic [8:0]          res_cnt;
    kar_pkg::t_age_req   age_req;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign rd_key   = r_rd_data[OFS_KEY +: KEY_BITS];
    assign rd_act   = r_rd_data[OFS_ACT];
    assign rd_last  = r_rd_data[OFS_LAST +: 32];
    assign rd_first = r_rd_data[31:0];

    assign key_match   = (rd_key == r_key);
    assign idx_last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign room        = (r_count < CW'(ENTRIES));
    assign hit_or_room = r_found || room;

    // a fresh entry starts inactive with zero times
    assign base_act   = r_found && rd_act;
    assign base_last  = r_found ? rd_last  : 32'd0;
    assign base_first = r_found ? rd_first : 32'd0;

    // shared age compare: debounce during sweep, rate limit otherwise
    always_comb begin
        age_req.now = r_now;
        if (r_state == kar_pkg::ST_SWEEP) begin
            age_req.stamp = rd_first;
            age_req.limit = r_deb;
        end else begin
            age_req.stamp = base_last;
            age_req.limit = r_rate;
        end
    end

    kar_age_unit u_age (
        .i_req (age_req),
        .o_ge  (age_ge)
    );

    assign start_ok = !base_act || age_ge;

    always_comb begin
        new_act   = base_act;
        new_last  = base_last;
        new_first = base_first;
        unique case (r_action)
            kar_pkg::ACT_START: begin
                if (start_ok) begin
                    new_act   = 1'b1;
                    new_last  = r_now;
                    new_first = base_act ? base_first : r_now;
                end
            end
            kar_pkg::ACT_STOP: begin
                new_act   = 1'b0;
                new_first = 32'd0;
            end
            kar_pkg::ACT_QUERY, kar_pkg::ACT_SWEEP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_action == kar_pkg::ACT_SWEEP) begin
            res_bc   = 1'b0;
            res_typ  = 1'b0;
            res_full = 1'b0;
            res_cnt  = (32'(r_n) > 32'(kar_pkg::STOPPED_MAX)) ?
                       kar_pkg::STOPPED_MAX : 9'(r_n);
        end else begin
            res_bc   = hit_or_room && (r_action == kar_pkg::ACT_START) && start_ok;
            res_typ  = hit_or_room && new_act;
            res_full = !hit_or_room;
            res_cnt  = 9'd0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kar_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (r_count == '0) begin
                        n_state = kar_pkg::ST_APPLY;
                    end else if (kar_pkg::t_action'(i_action) == kar_pkg::ACT_SWEEP) begin
                        n_state = kar_pkg::ST_SWEEP;
                    end else begin
                        n_state = kar_pkg::ST_SCAN;
                    end
                end
            end
            kar_pkg::ST_SCAN: begin
                if (key_match || idx_last) begin
                    n_state = kar_pkg::ST_APPLY;
                end
            end
            kar_pkg::ST_SWEEP: begin
                if (idx_last) begin
                    n_state = kar_pkg::ST_APPLY;
                end
            end
            kar_pkg::ST_APPLY: begin
                if (out_free) begin
                    n_state = kar_pkg::ST_IDLE;
                end
            end
            default: n_state = kar_pkg::ST_IDLE;
        endcase
    end

    // control outputs: memory ports and handshake
    always_comb begin
        o_in_ready  = (r_state == kar_pkg::ST_IDLE);
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_we      = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = {rd_key, 1'b0, rd_last, 32'd0};
        unique case (r_state)
            kar_pkg::ST_IDLE: begin
                mem_rd_en = in_fire;
            end
            kar_pkg::ST_SCAN: begin
                mem_rd_en   = !key_match && !idx_last;
                mem_rd_addr = r_idx + 1'b1;
            end
            kar_pkg::ST_SWEEP: begin
                mem_rd_en   = !idx_last;
                mem_rd_addr = r_idx + 1'b1;
                // stop a stale entry, keep its key and last start
                mem_we      = rd_act && age_ge;
            end
            kar_pkg::ST_APPLY: begin
                mem_we      = out_free && (r_action != kar_pkg::ACT_SWEEP) && hit_or_room;
                mem_wr_addr = r_found ? r_idx : r_count[AW-1:0];
                mem_wr_data = {r_key, new_act, new_last, new_first};
            end
            default: begin
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_idx   = r_idx;
        n_found = r_found;
        n_n     = r_n;
        n_count = r_count;
        unique case (r_state)
            kar_pkg::ST_IDLE: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_n     = '0;
            end
            kar_pkg::ST_SCAN: begin
                n_found = key_match;
                if (!key_match && !idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            kar_pkg::ST_SWEEP: begin
                if (rd_act && age_ge) begin
                    n_n = r_n + 1'b1;
                end
                if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            kar_pkg::ST_APPLY: begin
                if (out_free && (r_action != kar_pkg::ACT_SWEEP) && !r_found && room) begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_entry[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= m_entry[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kar_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rate      <= kar_pkg::RATE_LIMIT_RESET;
            r_deb       <= kar_pkg::DEBOUNCE_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == kar_pkg::ST_APPLY) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    kar_pkg::CFG_RATE_LIMIT: r_rate <= i_cfg_data;
                    kar_pkg::CFG_DEBOUNCE:   r_deb  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_found <= n_found;
        r_n     <= n_n;
        if (in_fire) begin
            r_action <= kar_pkg::t_action'(i_action);
            r_key    <= i_user_key[KEY_BITS-1:0];
            r_now    <= i_now_seconds;
        end
        if ((r_state == kar_pkg::ST_APPLY) && out_free) begin
            r_bc   <= res_bc;
            r_typ  <= res_typ;
            r_cnt  <= res_cnt;
            r_full <= res_full;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_broadcast     = r_bc;
    assign o_typing        = r_typ;
    assign o_stopped_count = r_cnt;
    assign o_no_room       = r_full;

    `KAR_ASSERT_NOW(a_scan_idx_in_table, (r_state == kar_pkg::ST_SCAN) || (r_state == kar_pkg::ST_SWEEP), CW'(r_idx) < r_count, "scan index beyond stored entries")
    `KAR_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= CW'(ENTRIES), "entry count exceeds table size")
    `KAR_ASSERT_NOW(a_count_grows_in_apply, n_count != r_count, (r_state == kar_pkg::ST_APPLY) && (n_count == r_count + 1'b1), "entry count changed outside append")
    `KAR_ASSERT_NEXT(a_result_loaded, (r_state == kar_pkg::ST_APPLY) && out_free, r_out_valid && (r_state == kar_pkg::ST_IDLE), "result not loaded after final step")
    `KAR_ASSERT_NOW(a_no_room_when_full, r_out_valid && r_full, r_count == CW'(ENTRIES), "no room reported with free entries")

endmodule
`default_nettype wire

// ===== design/kar_age_unit.sv =====
`default_nettype none
module kar_age_unit (
    input  kar_pkg::t_age_req i_req,
    output logic              o_ge
);

    logic [31:0] age;

    // wrap modulo 2^32, then compare against the zero-extended limit
    assign age  = i_req.now - i_req.stamp;
    assign o_ge = (age >= {16'd0, i_req.limit});

endmodule
`default_nettype wire
